FILE: src/rrof_pkg.sv
package rrof_pkg;

    localparam int MAX_LEN     = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int IDX_BITS    = $clog2(MAX_LEN);
    localparam int LEN_BITS    = $clog2(MAX_LEN + 1);
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = LEN_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_BITS-1:0]           idx_t;
    typedef logic [LEN_BITS-1:0]           len_t;
    typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_BITS-1:0]      cfg_data_t;

    localparam cfg_idx_t REG_WINDOW_LEN = CFG_IDX_BITS'(0);
    localparam cfg_idx_t REG_RANK       = CFG_IDX_BITS'(1);

    // One stored entry of the sorted window.
    typedef struct packed {
        sample_t value;
        idx_t    age;
    } entry_t;

    // Handed from a cell to its right neighbor in the same cycle.
    typedef struct packed {
        logic    del_seen;  // oldest entry sits at this position or further left
        logic    lt;        // compacted entry here is below the new sample
        sample_t c_value;   // entry after the oldest one is removed
        idx_t    c_age;     // its age, already advanced
    } link_t;

    // Broadcast to every cell.
    typedef struct packed {
        logic    shift;
        logic    clear;
        len_t    len;
        idx_t    age_max;
        sample_t sample;
    } cell_ctrl_t;

endpackage

FILE: src/rrof_cell.sv
module rrof_cell
    import rrof_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  idx_t       index,
    input  link_t      left_in,
    input  entry_t     right_in,
    output link_t      link_out,
    output entry_t     entry_out
);

    sample_t value_reg;
    sample_t value_next;
    idx_t    age_reg;
    idx_t    age_next;

    logic    active;
    logic    last;
    logic    oldest;
    logic    del_le;
    sample_t c_value;
    idx_t    c_age;
    logic    lt;

    assign active = {1'b0, index} < ctrl.len;
    assign last   = {1'b0, index} == (ctrl.len - LEN_BITS'(1));
    assign oldest = active && (age_reg >= ctrl.age_max);
    assign del_le = left_in.del_seen || oldest;

    // Close the gap left by the oldest entry, then age by one.
    assign c_value = del_le ? right_in.value : value_reg;
    assign c_age   = (del_le ? right_in.age : age_reg) + IDX_BITS'(1);
    assign lt      = active && !last && ($signed(c_value) < $signed(ctrl.sample));

    assign link_out.del_seen = del_le;
    assign link_out.lt       = lt;
    assign link_out.c_value  = c_value;
    assign link_out.c_age    = c_age;

    assign entry_out.value = value_reg;
    assign entry_out.age   = age_reg;

    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.clear)
        begin
            value_next = '0;
            age_next   = index;
        end
        else if (ctrl.shift && active)
        begin
            priority if (lt)
            begin
                value_next = c_value;
                age_next   = c_age;
            end
            else if (left_in.lt)
            begin
                // insert the new sample here
                value_next = ctrl.sample;
                age_next   = '0;
            end
            else
            begin
                value_next = left_in.c_value;
                age_next   = left_in.c_age;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            age_reg   <= '0;
        end
        else
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

endmodule

FILE: src/running_rank_order_filter.sv
// Running rank-order filter over a sliding window of signed Q1.23 samples.
// Input channel (sample_in, in_valid/in_ready): one sample per beat. Each
// accepted beat evicts the oldest sample of the window, inserts the new one
// in sorted position and yields exactly one beat on the output channel
// (ranked_sample, out_valid/out_ready): the window value at the configured
// rank, clamped to window_len-1.
// Configuration channel (cfg_index, cfg_data, cfg_valid/cfg_ready): index 0
// writes window_len (0 taken as 1, above 64 taken as 64), clears the window
// to zeros and sets rank to window_len/2; index 1 writes rank. Write only
// while no sample is in flight.
// A row of 64 cells updates the whole sorted window at the edge of the
// input beat; the rank tap is then read from the cells into the output
// register (out_reg) once that register is free. Throughput: one sample
// per cycle while out_ready stays high.
// Reset: window_len 1, rank 0, window holds a single zero.
// Stall: while out_ready is low one result waits in the output register and
// one more in the cell row; in_ready then drops until the output drains.
module running_rank_order_filter
    import rrof_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_idx_t  cfg_index,
    input  cfg_data_t cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  sample_t   sample_in,
    output logic      out_valid,
    input  logic      out_ready,
    output sample_t   ranked_sample
);

    len_t    len_reg;
    len_t    len_next;
    idx_t    rank_reg;
    idx_t    rank_next;
    logic    pend_reg;
    logic    pend_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t out_reg;
    sample_t out_next;

    logic       cfg_fire;
    logic       in_fire;
    logic       move;
    cell_ctrl_t ctrl;
    idx_t       rank_eff;
    len_t       wr_len;

    link_t  links   [MAX_LEN+1];
    entry_t entries [MAX_LEN+1];

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign move      = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_reg || move;
    assign in_fire   = in_valid && in_ready;

    assign ctrl.shift   = in_fire;
    assign ctrl.clear   = cfg_fire && (cfg_index == REG_WINDOW_LEN);
    assign ctrl.len     = len_reg;
    assign ctrl.age_max = IDX_BITS'(len_reg - LEN_BITS'(1));
    assign ctrl.sample  = sample_in;

    assign links[0].del_seen = 1'b0;
    assign links[0].lt       = 1'b1;
    assign links[0].c_value  = '0;
    assign links[0].c_age    = '0;
    assign entries[MAX_LEN]  = '0;

    for (genvar p = 0; p < MAX_LEN; p++)
    begin : g_cell
        rrof_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .index     (IDX_BITS'(p)),
            .left_in   (links[p]),
            .right_in  (entries[p+1]),
            .link_out  (links[p+1]),
            .entry_out (entries[p])
        );
    end

    assign rank_eff = ({1'b0, rank_reg} >= len_reg) ? IDX_BITS'(len_reg - LEN_BITS'(1))
                                                     : rank_reg;

    // Tap the cell at the effective rank.
    always_comb
    begin
        out_next = out_reg;
        if (move)
        begin
            out_next = '0;
            for (int p = 0; p < MAX_LEN; p++)
            begin
                if (IDX_BITS'(p) == rank_eff)
                begin
                    out_next = out_next | entries[p].value;
                end
            end
        end
    end

    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            wr_len = LEN_BITS'(1);
        end
        else if (cfg_data > CFG_DATA_BITS'(MAX_LEN))
        begin
            wr_len = LEN_BITS'(MAX_LEN);
        end
        else
        begin
            wr_len = LEN_BITS'(cfg_data);
        end
    end

    always_comb
    begin
        len_next  = len_reg;
        rank_next = rank_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_WINDOW_LEN:
                begin
                    len_next  = wr_len;
                    rank_next = IDX_BITS'(wr_len >> 1);
                end
                REG_RANK:
                begin
                    rank_next = IDX_BITS'(cfg_data);
                end
                default:
                begin
                    rank_next = rank_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        pend_next      = in_fire ? 1'b1 : (move ? 1'b0 : pend_reg);
        out_valid_next = move ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_BITS'(1);
            rank_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            rank_reg      <= rank_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign ranked_sample = out_reg;

endmodule

FILE: test/rank_filter_checker.sv
module rank_filter_checker
    import rrof_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  cfg_idx_t  cfg_index,
    input  cfg_data_t cfg_data,
    input  logic      in_valid,
    input  logic      in_ready,
    input  sample_t   sample_in,
    input  logic      out_valid,
    input  logic      out_ready,
    input  sample_t   ranked_sample,
    output int        errors,
    output int        pending,
    output int        results
);

    timeunit 1ns;
    timeprecision 1ps;

    sample_t win_val [MAX_LEN];
    int      win_age [MAX_LEN];
    int      win_len;
    int      sel_rank;
    sample_t expected_ranked [$];

    initial errors = 0;

    task automatic report(string msg);
        $display("ERROR %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_window();
        for (int p = 0; p < MAX_LEN; p++)
        begin
            win_val[p] = '0;
            win_age[p] = p;
        end
    endtask

    // Evict the oldest sample, insert x ahead of the first value >= x, tap the rank.
    task automatic rank_insert(input sample_t x, output sample_t y);
        int del;
        int ins;
        int p;
        del = win_len - 1;
        for (p = 0; p < win_len; p++)
        begin
            if (win_age[p] >= win_len - 1)
            begin
                del = p;
                break;
            end
        end
        for (p = del; p + 1 < win_len; p++)
        begin
            win_val[p] = win_val[p + 1];
            win_age[p] = win_age[p + 1];
        end
        for (p = 0; p + 1 < win_len; p++)
            win_age[p] = win_age[p] + 1;
        ins = win_len - 1;
        for (p = 0; p + 1 < win_len; p++)
        begin
            if (win_val[p] >= x)
            begin
                ins = p;
                break;
            end
        end
        for (p = win_len - 1; p > ins; p--)
        begin
            win_val[p] = win_val[p - 1];
            win_age[p] = win_age[p - 1];
        end
        win_val[ins] = x;
        win_age[ins] = 0;
        y = win_val[(sel_rank >= win_len) ? win_len - 1 : sel_rank];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        sample_t got;
        if (!rst_n)
        begin
            win_len = 1;
            sel_rank = 0;
            clear_window();
            expected_ranked.delete();
            pending = 0;
            results = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results++;
                if (expected_ranked.size() == 0)
                    report($sformatf("result %0d (%0d) with nothing expected",
                                     results, ranked_sample));
                else
                begin
                    want = expected_ranked.pop_front();
                    if (ranked_sample !== want)
                        report($sformatf("result %0d: ranked_sample %0d, expected %0d",
                                         results, ranked_sample, want));
                end
            end
            if (in_valid && in_ready)
            begin
                rank_insert(sample_in, got);
                expected_ranked.push_back(got);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WINDOW_LEN)
                begin
                    if (cfg_data == '0)
                        win_len = 1;
                    else if (int'(cfg_data) > MAX_LEN)
                        win_len = MAX_LEN;
                    else
                        win_len = int'(cfg_data);
                    clear_window();
                    sel_rank = win_len / 2;
                end
                else if (cfg_index == REG_RANK)
                    sel_rank = int'(cfg_data[IDX_BITS-1:0]);
            end
            pending = expected_ranked.size();
        end
    end

endmodule

FILE: test/running_rank_order_filter_tb.sv
module running_rank_order_filter_tb;

    import rrof_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      STALL_LIMIT = 2000;
    localparam int      HOLD_CYCLES = 300;
    localparam int      RANDOM_ITEMS = 550;
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;
    logic      in_valid;
    logic      in_ready;
    sample_t   sample_in;
    logic      out_valid;
    logic      out_ready;
    sample_t   ranked_sample;

    int check_errors;
    int check_pending;
    int check_results;
    int n_samples;
    int n_writes;
    bit steady;
    bit hold_req;

    running_rank_order_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ranked_sample (ranked_sample)
    );

    rank_filter_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ranked_sample (ranked_sample),
        .errors        (check_errors),
        .pending       (check_pending),
        .results       (check_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small values give plenty of ties; extremes and full-range words cover every bit.
    function automatic sample_t pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return SAMPLE_MAX;
        if (roll < 8)
            return SAMPLE_MIN;
        if (roll < 45)
            return sample_t'($urandom_range(0, 15)) - sample_t'(8);
        return sample_t'($urandom);
    endfunction

    // Starts after the previous beat's edge; returns at the accepting edge.
    task automatic send_sample(input sample_t x);
        int gap;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_samples++;
    endtask

    // Write only once the window has drained.
    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
        @(negedge clk);
        in_valid <= 1'b0;
        while (check_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Output side: random back-pressure, plus one long hold on request.
    initial
    begin
        int gap;
        gap = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (gap > 0)
            begin
                out_ready <= 1'b0;
                gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                gap = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no beat on any channel for %0d cycles", STALL_LIMIT);
        $display("FAIL running_rank_order_filter");
        $finish;
    end

    initial
    begin
        int phase;
        int len_w;
        int count;
        int random_sent;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_LEN;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample_in = '0;
        steady    = 1'b0;
        hold_req  = 1'b0;
        n_samples = 0;
        n_writes  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset window of one: every sample comes straight back.
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'(0));
        // Zero length is taken as one.
        write_reg(REG_WINDOW_LEN, cfg_data_t'(0));
        send_sample(sample_t'(5));
        // Five-tap median with ties and extremes.
        write_reg(REG_WINDOW_LEN, cfg_data_t'(5));
        send_sample(sample_t'(3));
        send_sample(sample_t'(3));
        send_sample(sample_t'(-1));
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'(3));
        send_sample(sample_t'(3));
        // Rank beyond the window clamps to the top entry.
        write_reg(REG_RANK, cfg_data_t'(7'h7F));
        send_sample(sample_t'(7));
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'(2));
        write_reg(REG_RANK, cfg_data_t'(0));
        send_sample(sample_t'(1));
        send_sample(sample_t'(-1));
        send_sample(SAMPLE_MAX);

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case (phase)
                0: len_w = 127;
                1: len_w = 64;
                2: len_w = 2;
                3: len_w = 1;
                default:
                begin
                    count = $urandom_range(0, 9);
                    if (count < 2)
                        len_w = 64;
                    else if (count < 3)
                        len_w = $urandom_range(0, 3);
                    else
                        len_w = $urandom_range(1, 64);
                end
            endcase
            write_reg(REG_WINDOW_LEN, cfg_data_t'(len_w));
            if (phase == 1 || $urandom_range(0, 2) == 0)
                write_reg(REG_RANK, cfg_data_t'($urandom_range(0, 127)));
            steady = ($urandom_range(0, 3) == 0);
            // Stall the output while the sender keeps pushing a long window.
            if (phase == 1)
                hold_req = 1'b1;
            count = ((len_w > MAX_LEN) ? MAX_LEN : (len_w < 1 ? 1 : len_w))
                    + $urandom_range(10, 40);
            if (count > RANDOM_ITEMS - random_sent)
                count = RANDOM_ITEMS - random_sent;
            repeat (count)
                send_sample(pick_sample());
            random_sent += count;
            steady = 1'b0;
            phase++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (check_pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        $display("drove %0d samples and %0d register writes over %0d window settings",
                 n_samples, n_writes, phase + 3);
        $display("checked %0d ranked results, incl. a %0d-cycle output stall",
                 check_results, HOLD_CYCLES);
        if (check_errors == 0)
            $display("PASS running_rank_order_filter");
        else
            $display("FAIL running_rank_order_filter");
        $finish;
    end

endmodule
